[sv/fbp_pkg.sv]
// fbp_pkg: shared types, constants and the piece decode of the fen board parser
// no dependencies

package fbp_pkg;

	localparam int ROW_SQUARES = 8;
	localparam int ROW_COUNT   = 8;

	localparam int FILE_W = $clog2(ROW_SQUARES + 1);
	localparam int RANK_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int RUN_W  = 4;
	localparam int SUM_W  = 5;

	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_WK    = 8'h4b;
	localparam logic [7:0] CH_WQ    = 8'h51;
	localparam logic [7:0] CH_WR    = 8'h52;
	localparam logic [7:0] CH_WB    = 8'h42;
	localparam logic [7:0] CH_WN    = 8'h4e;
	localparam logic [7:0] CH_WP    = 8'h50;
	localparam logic [7:0] CH_BK    = 8'h6b;
	localparam logic [7:0] CH_BQ    = 8'h71;
	localparam logic [7:0] CH_BR    = 8'h72;
	localparam logic [7:0] CH_BB    = 8'h62;
	localparam logic [7:0] CH_BN    = 8'h6e;
	localparam logic [7:0] CH_BP    = 8'h70;

	typedef logic [3:0] piece_t;

	localparam piece_t PC_EMPTY = 4'd0;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_ROW_LONG  = 3'd1,
		ERR_ROW_SHORT = 3'd2,
		ERR_MANY_ROWS = 3'd3,
		ERR_BAD_CHAR  = 3'd4,
		ERR_FEW_ROWS  = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		KIND_END,
		KIND_DIGIT,
		KIND_SLASH,
		KIND_PIECE,
		KIND_BAD
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load_item;
		logic step;
	} fbp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last;
	} fbp_status_t;

	function automatic piece_t piece_of(input logic [7:0] c);
		piece_t pc;
		unique case (c)
			CH_WK:   pc = 4'd1;
			CH_WQ:   pc = 4'd2;
			CH_WR:   pc = 4'd3;
			CH_WB:   pc = 4'd4;
			CH_WN:   pc = 4'd5;
			CH_WP:   pc = 4'd6;
			CH_BK:   pc = 4'd7;
			CH_BQ:   pc = 4'd8;
			CH_BR:   pc = 4'd9;
			CH_BB:   pc = 4'd10;
			CH_BN:   pc = 4'd11;
			CH_BP:   pc = 4'd12;
			default: pc = PC_EMPTY;
		endcase
		return pc;
	endfunction

endpackage

[sv/fbp_ifs.sv]
// fbp_ifs: valid/ready channel interfaces for characters in and square results out
// no dependencies

interface fbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

interface fbp_out_if;
	logic       valid;
	logic       ready;
	logic       write_valid;
	logic [2:0] square_file;
	logic [2:0] square_rank;
	logic [3:0] piece_code;
	logic [2:0] error_code;
	logic       last_of_run;

	modport source (output valid, output write_valid, output square_file,
		output square_rank, output piece_code, output error_code,
		output last_of_run, input ready);
	modport sink (input valid, input write_valid, input square_file,
		input square_rank, input piece_code, input error_code,
		input last_of_run, output ready);
endinterface

[sv/fen_board_parser.sv]
// fen_board_parser: top level, joins controller and datapath to the channels
// depends on fbp_pkg, fbp_ifs, fbp_ctrl, fbp_dp
//
//   channel   dir   payload                                        handshake
//   chars     in    char_code, end_of_string                       valid/ready
//   squares   out   write_valid, square_file, square_rank,         valid/ready
//                   piece_code, error_code, last_of_run
//
// each character is accepted, then its results are stepped out: one result for a
// piece, slash, bad character or end marker, up to eight for a digit run, paced by
// the single output register, filled one transaction per cycle while it is free
// reset sets row position to the top rank, clears file count and sticky error; no clearing pass
// a stall on squares holds the run; chars is ready again once the last result
// is in the output register, while that result still waits to be taken

module fen_board_parser
	import fbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fbp_in_if.sink    chars,
	fbp_out_if.source squares
);

	fbp_cmd_t    cmd;
	fbp_status_t status;
	logic        in_ready;

	assign chars.ready = in_ready;

	fbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fbp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.char_code     (chars.char_code),
		.end_of_string (chars.end_of_string),
		.squares       (squares)
	);

endmodule

[sv/fbp_ctrl.sv]
// fbp_ctrl: controller state machine, takes one character then steps its results
// depends on fbp_pkg

module fbp_ctrl
	import fbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  fbp_status_t status,
	output fbp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.step      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.slot_free) begin
					cmd.step = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !cmd.load_item)
		else $error("item loaded while a run is in progress");

	a_step_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> state_q == ST_RUN && status.slot_free)
		else $error("step issued without a free output slot");

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> state_q == ST_RUN)
		else $error("accepted item did not start a run");

endmodule

[sv/fbp_dp.sv]
// fbp_dp: datapath with item decode, parse state, run counter and output register
// depends on fbp_pkg and fbp_ifs

module fbp_dp
	import fbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fbp_cmd_t    cmd,
	output fbp_status_t status,
	input  logic [7:0]  char_code,
	input  logic        end_of_string,
	fbp_out_if.source   squares
);

	kind_t              kind_q;
	logic [RUN_W-1:0]   left_q;
	piece_t             pc_q;
	logic [FILE_W-1:0]  file_q;
	logic [RANK_W-1:0]  rank_q;
	err_t               err_q;

	logic               out_valid_q;
	logic               wv_q;
	logic [2:0]         file_out_q;
	logic [2:0]         rank_out_q;
	piece_t             pc_out_q;
	err_t               err_out_q;
	logic               last_out_q;

	kind_t              kind_d;
	piece_t             pc_dec;
	logic [SUM_W-1:0]   run_end;
	logic [FILE_W+2:0]  file_wide;
	logic [RANK_W+2:0]  rank_wide;

	logic               res_wv;
	err_t               res_err;
	logic               res_last;
	logic [FILE_W-1:0]  file_d;
	logic [RANK_W-1:0]  rank_d;
	err_t               err_d;
	logic [RUN_W-1:0]   left_d;

	assign pc_dec = piece_of(char_code);

	always_comb begin
		if (end_of_string) begin
			kind_d = KIND_END;
		end else if (char_code >= CH_ONE && char_code <= CH_EIGHT) begin
			kind_d = KIND_DIGIT;
		end else if (char_code == CH_SLASH) begin
			kind_d = KIND_SLASH;
		end else if (pc_dec != PC_EMPTY) begin
			kind_d = KIND_PIECE;
		end else begin
			kind_d = KIND_BAD;
		end
	end

	// item register, written on acceptance; the run counter also counts down on each step
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind_d;
			pc_q   <= pc_dec;
			left_q <= (kind_d == KIND_DIGIT) ? char_code[RUN_W-1:0] : RUN_W'(1);
		end else if (cmd.step) begin
			left_q <= left_d;
		end
	end

	assign run_end   = SUM_W'(file_q) + SUM_W'(left_q);
	assign file_wide = {3'b000, file_q};
	assign rank_wide = {3'b000, rank_q};

	always_comb begin
		res_wv   = 1'b0;
		res_last = 1'b1;
		file_d   = file_q;
		rank_d   = rank_q;
		err_d    = err_q;
		left_d   = left_q;
		res_err  = err_q;
		if (kind_q == KIND_END) begin
			if (err_q == ERR_NONE) begin
				if (rank_q != '0) begin
					res_err = ERR_FEW_ROWS;
				end else if (SUM_W'(file_q) != SUM_W'(ROW_SQUARES)) begin
					res_err = ERR_ROW_SHORT;
				end
			end
			file_d = '0;
			rank_d = RANK_W'(ROW_COUNT - 1);
			err_d  = ERR_NONE;
		end else if (err_q == ERR_NONE) begin
			case (kind_q)
				KIND_DIGIT, KIND_PIECE: begin
					if (run_end > SUM_W'(ROW_SQUARES)) begin
						err_d = ERR_ROW_LONG;
					end else begin
						res_wv   = 1'b1;
						res_last = (left_q == RUN_W'(1));
						file_d   = FILE_W'(file_q + 1'b1);
						left_d   = RUN_W'(left_q - 1'b1);
					end
				end
				KIND_SLASH: begin
					if (SUM_W'(file_q) != SUM_W'(ROW_SQUARES)) begin
						err_d = ERR_ROW_SHORT;
					end else if (rank_q == '0) begin
						err_d = ERR_MANY_ROWS;
					end else begin
						file_d = '0;
						rank_d = RANK_W'(rank_q - 1'b1);
					end
				end
				default: err_d = ERR_BAD_CHAR;
			endcase
			res_err = err_d;
		end
	end

	assign status.slot_free = !out_valid_q || squares.ready;
	assign status.last      = res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_q      <= '0;
			rank_q      <= RANK_W'(ROW_COUNT - 1);
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				file_q      <= file_d;
				rank_q      <= rank_d;
				err_q       <= err_d;
				out_valid_q <= 1'b1;
			end else if (squares.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			wv_q       <= res_wv;
			file_out_q <= res_wv ? file_wide[2:0] : 3'd0;
			rank_out_q <= res_wv ? rank_wide[2:0] : 3'd0;
			pc_out_q   <= (res_wv && kind_q == KIND_PIECE) ? pc_q : PC_EMPTY;
			err_out_q  <= res_err;
			last_out_q <= res_last;
		end
	end

	assign squares.valid       = out_valid_q;
	assign squares.write_valid = wv_q;
	assign squares.square_file = file_out_q;
	assign squares.square_rank = rank_out_q;
	assign squares.piece_code  = pc_out_q;
	assign squares.error_code  = err_out_q;
	assign squares.last_of_run = last_out_q;

	a_file_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(file_q) <= SUM_W'(ROW_SQUARES))
		else $error("file count past row length");

	a_write_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		squares.valid && squares.write_valid |-> squares.error_code == ERR_NONE)
		else $error("square write carries an error");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && kind_q != KIND_END && err_q != ERR_NONE |=> err_q == $past(err_q))
		else $error("sticky error changed before end of string");

	a_step_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> squares.valid)
		else $error("step did not fill the output register");

endmodule
